@@ design/isotp_pkg.sv @@
package isotp_pkg;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 12;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 104;
    localparam int M_DATA_W  = 176;

    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;
    localparam logic [3:0] FT_FLOW   = 4'h3;

    localparam logic [CFG_IDX_W-1:0] CFG_RX_ID       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_BLOCK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_STMIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_BYTE   = 3'd4;

    localparam logic [7:0] FC_CONTINUE  = 8'h30;
    localparam logic [7:0] STMIN_MS_MAX = 8'h7F;
    localparam logic [7:0] STMIN_US_MIN = 8'hF1;
    localparam logic [7:0] STMIN_US_MAX = 8'hF9;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_mod_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_mod_sts;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] write_offset;
        logic [2:0]       byte_count;
        logic [55:0]      data_bytes;
        logic             message_done;
        logic [LEN_W-1:0] message_length;
        logic             flow_send;
        logic [63:0]      flow_frame;
        logic [3:0]       flow_frame_len;
        logic [7:0]       remote_block;
        logic [7:0]       remote_stmin;
        logic [3:0]       remote_status;
    } t_result;

endpackage

@@ design/isotp_mod_unit.sv @@
module isotp_mod_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isotp_pkg::t_mod_ctl i_ctl,
    output isotp_pkg::t_mod_sts o_sts
);
    import isotp_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);

    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    c_trial;
    logic [CNT_W-1:0]  n_rem;

    always_comb begin
        c_trial = {r_rem, r_dvd[CNT_W-1]};
        if (c_trial >= {1'b0, r_div}) begin
            n_rem = CNT_W'(c_trial - {1'b0, r_div});
        end else begin
            n_rem = c_trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_dvd  <= i_ctl.dividend;
                r_div  <= i_ctl.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[CNT_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.rem_zero = (r_rem == '0);

endmodule

@@ design/isotp_frame_reassembler_top.sv @@
// Receive side of a CAN transport layer: one received CAN frame per input word, at most one
// result word per frame. An accepted frame is captured, decoded into a pending result, then
// copied to the result register; a consecutive frame with nonzero block size goes first through
// the bit-serial remainder unit, testing the frame counter against the block size one bit per
// cycle. The input is not ready while a frame is being worked on. The result register lets
// the next frame be accepted while the previous result waits; a frame finishing while that
// register is still full waits until it is taken. Frames for another identifier, with a type
// above flow control, or consecutive frames with no reception open give no result.
module isotp_frame_reassembler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // can_id, frame_bytes, frame_len, zero fill
    input  logic [isotp_pkg::S_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // write_offset, byte_count, data_bytes, message_length, flow_send, flow_frame,
    // flow_frame_len, remote_block, remote_stmin, remote_status, zero fill
    output logic [isotp_pkg::M_DATA_W-1:0]      o_m_tdata,
    // kind
    output logic [1:0]                          o_m_tuser,
    // message_done
    output logic                                o_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [isotp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [isotp_pkg::ID_W-1:0]          i_cfg_wdata
);
    import isotp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_MOD, S_EMIT} t_state;

    t_state           r_state;
    logic [ID_W-1:0]  r_in_id;
    logic [63:0]      r_in_frame;

    logic [ID_W-1:0]  r_rx_id;
    logic [7:0]       r_flow_block;
    logic [7:0]       r_flow_stmin;
    logic             r_fill_enable;
    logic [7:0]       r_fill_byte;

    logic [LEN_W-1:0] r_total;
    logic [LEN_W-1:0] r_recv;
    logic [CNT_W-1:0] r_fcnt;
    logic             r_in_prog;
    logic [7:0]       r_p_block;
    logic [3:0]       r_p_status;
    logic [7:0]       r_p_stmin;

    t_result          r_pend;
    t_result          r_out;
    logic             r_out_valid;
    logic             r_mod_start;
    logic [CNT_W-1:0] r_mod_dvd;

    t_mod_ctl         c_mod_ctl;
    t_mod_sts         c_mod_sts;

    logic [7:0]       c_b0;
    logic [3:0]       c_type;
    logic [7:0]       c_stmin;
    logic [63:0]      c_flow;
    logic [3:0]       c_flen;
    logic [LEN_W-1:0] c_remain;
    logic [LEN_W-1:0] c_fl_total;
    logic [LEN_W-1:0] c_cf_recv;
    logic [2:0]       c_count;
    logic [1:0]       c_first;
    logic [63:0]      c_shift;
    logic [55:0]      c_data;
    logic             c_drop;
    logic             c_out_free;

    assign c_mod_ctl.start    = r_mod_start;
    assign c_mod_ctl.dividend = r_mod_dvd;
    assign c_mod_ctl.divisor  = r_flow_block;

    isotp_mod_unit u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (c_mod_ctl),
        .o_sts  (c_mod_sts)
    );

    always_comb begin
        c_b0   = r_in_frame[63:56];
        c_type = c_b0[7:4];

        if (r_flow_stmin <= STMIN_MS_MAX ||
            (r_flow_stmin >= STMIN_US_MIN && r_flow_stmin <= STMIN_US_MAX)) begin
            c_stmin = r_flow_stmin;
        end else begin
            c_stmin = 8'h00;
        end
        if (r_fill_enable) begin
            c_flow = {FC_CONTINUE, r_flow_block, c_stmin, {5{r_fill_byte}}};
            c_flen = 4'd8;
        end else begin
            c_flow = {FC_CONTINUE, r_flow_block, c_stmin, 40'h0};
            c_flen = 4'd3;
        end

        c_fl_total = {c_b0[3:0], r_in_frame[55:48]};
        c_remain   = r_total - r_recv;
        c_count    = 3'd0;
        c_first    = 2'd1;
        unique case (c_type)
            FT_SINGLE: begin
                c_count = (c_b0[3:0] > 4'd7) ? 3'd7 : c_b0[2:0];
            end
            FT_FIRST: begin
                c_first = 2'd2;
                c_count = (c_fl_total < LEN_W'(6)) ? c_fl_total[2:0] : 3'd6;
            end
            FT_CONSEC: begin
                c_count = (c_remain < LEN_W'(7)) ? c_remain[2:0] : 3'd7;
            end
            default: begin
                c_count = 3'd0;
            end
        endcase
        c_cf_recv = r_recv + LEN_W'(c_count);

        c_shift = r_in_frame << {c_first, 3'b000};
        c_data  = c_shift[63:8] & ~({56{1'b1}} >> {c_count, 3'b000});

        c_drop = (r_in_id != r_rx_id) || (c_type > FT_FLOW) ||
                 (c_type == FT_CONSEC && !r_in_prog);
    end

    assign c_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_id       <= '0;
            r_flow_block  <= 8'd8;
            r_flow_stmin  <= 8'd0;
            r_fill_enable <= 1'b1;
            r_fill_byte   <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RX_ID:       r_rx_id       <= i_cfg_wdata;
                CFG_FLOW_BLOCK:  r_flow_block  <= i_cfg_wdata[7:0];
                CFG_FLOW_STMIN:  r_flow_stmin  <= i_cfg_wdata[7:0];
                CFG_FILL_ENABLE: r_fill_enable <= i_cfg_wdata[0];
                CFG_FILL_BYTE:   r_fill_byte   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_recv      <= '0;
            r_fcnt      <= '0;
            r_in_prog   <= 1'b0;
            r_p_block   <= '0;
            r_p_status  <= '0;
            r_p_stmin   <= '0;
            r_out_valid <= 1'b0;
            r_mod_start <= 1'b0;
        end else begin
            r_mod_start <= 1'b0;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_in_id    <= i_s_tdata[ID_W-1:0];
                        r_in_frame <= i_s_tdata[ID_W+63:ID_W];
                        r_state    <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_pend.kind           <= c_type[1:0];
                    r_pend.write_offset   <= '0;
                    r_pend.byte_count     <= c_count;
                    r_pend.data_bytes     <= c_data;
                    r_pend.message_done   <= 1'b0;
                    r_pend.flow_send      <= 1'b0;
                    r_pend.flow_frame     <= '0;
                    r_pend.flow_frame_len <= '0;
                    r_pend.message_length <= r_total;
                    r_pend.remote_block   <= r_p_block;
                    r_pend.remote_stmin   <= r_p_stmin;
                    r_pend.remote_status  <= r_p_status;
                    r_state               <= S_EMIT;
                    if (c_drop) begin
                        r_state <= S_IDLE;
                    end else begin
                        unique case (c_type)
                            FT_SINGLE: begin
                                r_total               <= LEN_W'(c_count);
                                r_recv                <= LEN_W'(c_count);
                                r_in_prog             <= 1'b0;
                                r_pend.message_done   <= 1'b1;
                                r_pend.message_length <= LEN_W'(c_count);
                            end
                            FT_FIRST: begin
                                r_total               <= c_fl_total;
                                r_recv                <= LEN_W'(c_count);
                                r_fcnt                <= CNT_W'(1);
                                r_in_prog             <= (LEN_W'(c_count) != c_fl_total);
                                r_pend.message_done   <= (LEN_W'(c_count) == c_fl_total);
                                r_pend.message_length <= c_fl_total;
                                r_pend.flow_send      <= 1'b1;
                                r_pend.flow_frame     <= c_flow;
                                r_pend.flow_frame_len <= c_flen;
                            end
                            FT_CONSEC: begin
                                r_recv              <= c_cf_recv;
                                r_fcnt              <= r_fcnt + 1'b1;
                                r_pend.write_offset <= r_recv;
                                if (c_cf_recv == r_total) begin
                                    r_in_prog           <= 1'b0;
                                    r_pend.message_done <= 1'b1;
                                end
                                if (r_flow_block != 8'd0) begin
                                    r_mod_dvd   <= r_fcnt + 1'b1;
                                    r_mod_start <= 1'b1;
                                    r_state     <= S_MOD;
                                end
                            end
                            default: begin
                                r_p_block            <= r_in_frame[55:48];
                                r_p_status           <= c_b0[3:0];
                                r_p_stmin            <= r_in_frame[47:40];
                                r_pend.remote_block  <= r_in_frame[55:48];
                                r_pend.remote_status <= c_b0[3:0];
                                r_pend.remote_stmin  <= r_in_frame[47:40];
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (c_mod_sts.done) begin
                        if (c_mod_sts.rem_zero) begin
                            r_pend.flow_send      <= 1'b1;
                            r_pend.flow_frame     <= c_flow;
                            r_pend.flow_frame_len <= c_flen;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (c_out_free) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.message_done;
    assign o_m_tdata  = {4'h0, r_out.remote_status, r_out.remote_stmin, r_out.remote_block,
                         r_out.flow_frame_len, r_out.flow_frame, r_out.flow_send,
                         r_out.message_length, r_out.data_bytes, r_out.byte_count,
                         r_out.write_offset};

endmodule

@@ test/tb_isotp_frame_reassembler_top.sv @@
module tb_isotp_frame_reassembler_top;
    import isotp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ID_W-1:0]       i_cfg_wdata;

    class reassembly_tracker;
        t_result          msg_results[$];
        int               errors;
        logic [ID_W-1:0]  rx_id;
        logic [7:0]       blk;
        logic [7:0]       stmin;
        logic             fill_en;
        logic [7:0]       fill_byte;
        logic [LEN_W-1:0] total_len;
        logic [LEN_W-1:0] rcvd_len;
        logic [CNT_W-1:0] frame_cnt;
        logic             in_prog;
        logic             completed;
        logic             flow_seen;
        logic [7:0]       peer_block;
        logic [7:0]       peer_stmin;
        logic [3:0]       peer_status;

        function new();
            errors      = 0;
            rx_id       = '0;
            blk         = 8'd8;
            stmin       = '0;
            fill_en     = 1'b1;
            fill_byte   = '0;
            total_len   = '0;
            rcvd_len    = '0;
            frame_cnt   = '0;
            in_prog     = 1'b0;
            completed   = 1'b0;
            flow_seen   = 1'b0;
            peer_block  = '0;
            peer_stmin  = '0;
            peer_status = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] v);
            case (idx)
                CFG_RX_ID:       rx_id     = v;
                CFG_FLOW_BLOCK:  blk       = v[7:0];
                CFG_FLOW_STMIN:  stmin     = v[7:0];
                CFG_FILL_ENABLE: fill_en   = v[0];
                CFG_FILL_BYTE:   fill_byte = v[7:0];
                default: ;
            endcase
        endfunction

        function logic [55:0] pick_bytes(logic [63:0] fr, int first, int count);
            logic [55:0] v;
            v = '0;
            for (int k = 0; k < 7; k++) begin
                v = v << 8;
                if (k < count && first + k < 8)
                    v[7:0] = fr[63-8*(first+k) -: 8];
            end
            return v;
        endfunction

        function void build_flow(output logic [63:0] f, output logic [3:0] n);
            logic [7:0] st;
            st = stmin;
            if (!(st <= STMIN_MS_MAX || (st >= STMIN_US_MIN && st <= STMIN_US_MAX)))
                st = '0;
            f = {FC_CONTINUE, blk, st, 40'h0};
            if (fill_en) begin
                f[39:0] = {5{fill_byte}};
                n = 4'd8;
            end else begin
                n = 4'd3;
            end
        endfunction

        // returns 1 when the frame yields a result word
        function bit take_frame(logic [ID_W-1:0] id, logic [63:0] fr);
            t_result          r;
            logic [7:0]       b0;
            logic [3:0]       ftype;
            logic [LEN_W-1:0] remain;
            b0 = fr[63:56];
            ftype = b0[7:4];
            if (id != rx_id || ftype > FT_FLOW)
                return 0;
            r = '0;
            r.kind = ftype[1:0];
            case (ftype)
                FT_SINGLE: begin
                    r.byte_count = (b0[3:0] > 4'd7) ? 3'd7 : b0[2:0];
                    r.data_bytes = pick_bytes(fr, 1, r.byte_count);
                    total_len = {9'd0, r.byte_count};
                    rcvd_len = total_len;
                    completed = 1'b1;
                    in_prog = 1'b0;
                    r.message_done = 1'b1;
                end
                FT_FIRST: begin
                    total_len = {b0[3:0], fr[55:48]};
                    r.byte_count = (total_len < 6) ? total_len[2:0] : 3'd6;
                    r.data_bytes = pick_bytes(fr, 2, r.byte_count);
                    rcvd_len = {9'd0, r.byte_count};
                    frame_cnt = 8'd1;
                    r.message_done = (rcvd_len == total_len);
                    completed = r.message_done;
                    in_prog = !r.message_done;
                    build_flow(r.flow_frame, r.flow_frame_len);
                    r.flow_send = 1'b1;
                end
                FT_CONSEC: begin
                    if (!in_prog)
                        return 0;
                    remain = total_len - rcvd_len;
                    r.byte_count = (remain < 7) ? remain[2:0] : 3'd7;
                    r.write_offset = rcvd_len;
                    r.data_bytes = pick_bytes(fr, 1, r.byte_count);
                    rcvd_len = rcvd_len + {9'd0, r.byte_count};
                    frame_cnt = frame_cnt + 8'd1;
                    if (rcvd_len == total_len) begin
                        r.message_done = 1'b1;
                        completed = 1'b1;
                        in_prog = 1'b0;
                    end
                    if (blk != 0 && (frame_cnt % blk) == 0) begin
                        build_flow(r.flow_frame, r.flow_frame_len);
                        r.flow_send = 1'b1;
                    end
                end
                default: begin
                    flow_seen = 1'b1;
                    peer_block = fr[55:48];
                    peer_status = b0[3:0];
                    peer_stmin = fr[47:40];
                end
            endcase
            r.message_length = total_len;
            r.remote_block = peer_block;
            r.remote_stmin = peer_stmin;
            r.remote_status = peer_status;
            msg_results.push_back(r);
            return 1;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < PRINT_CAP)
                $display("mismatch in %s: got %0h, want %0h", what, got, want);
            errors++;
        endtask

        task match_result(logic [1:0] kind, logic done, logic [M_DATA_W-1:0] d);
            t_result w;
            t_result g;
            if (msg_results.size() == 0) begin
                report("unrequested word, kind", 64'(kind), 64'd0);
                return;
            end
            w = msg_results.pop_front();
            g.kind           = kind;
            g.message_done   = done;
            g.write_offset   = d[11:0];
            g.byte_count     = d[14:12];
            g.data_bytes     = d[70:15];
            g.message_length = d[82:71];
            g.flow_send      = d[83];
            g.flow_frame     = d[147:84];
            g.flow_frame_len = d[151:148];
            g.remote_block   = d[159:152];
            g.remote_stmin   = d[167:160];
            g.remote_status  = d[171:168];
            if (g.kind != w.kind) report("kind", g.kind, w.kind);
            if (g.write_offset != w.write_offset)
                report("write_offset", g.write_offset, w.write_offset);
            if (g.byte_count != w.byte_count) report("byte_count", g.byte_count, w.byte_count);
            if (g.data_bytes != w.data_bytes) report("data_bytes", g.data_bytes, w.data_bytes);
            if (g.message_done != w.message_done)
                report("message_done", g.message_done, w.message_done);
            if (g.message_length != w.message_length)
                report("message_length", g.message_length, w.message_length);
            if (g.flow_send != w.flow_send) report("flow_send", g.flow_send, w.flow_send);
            if (g.flow_frame != w.flow_frame) report("flow_frame", g.flow_frame, w.flow_frame);
            if (g.flow_frame_len != w.flow_frame_len)
                report("flow_frame_len", g.flow_frame_len, w.flow_frame_len);
            if (g.remote_block != w.remote_block)
                report("remote_block", g.remote_block, w.remote_block);
            if (g.remote_stmin != w.remote_stmin)
                report("remote_stmin", g.remote_stmin, w.remote_stmin);
            if (g.remote_status != w.remote_status)
                report("remote_status", g.remote_status, w.remote_status);
        endtask
    endclass

    reassembly_tracker tracker;
    int send_pct;
    int recv_pct;
    int made;
    int cycles = 0;
    bit hold_rx;

    isotp_frame_reassembler_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= !hold_rx && ($urandom_range(99) >= recv_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.match_result(o_m_tuser, o_m_tlast, o_m_tdata);
    end

    function logic [63:0] frame_with(logic [7:0] b0, logic [7:0] b1);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[63:48] = {b0, b1};
        return v;
    endfunction

    function logic [7:0] pick_stmin();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return STMIN_MS_MAX;
            2:       return STMIN_US_MIN;
            3:       return STMIN_US_MAX;
            4:       return 8'($urandom_range(STMIN_US_MIN - 1, STMIN_MS_MAX + 1));
            default: return 8'($urandom_range(8'hFF, STMIN_US_MAX + 1));
        endcase
    endfunction

    task automatic send_word(logic [S_DATA_W-1:0] w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= w;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (tracker.take_frame(w[28:0], w[92:29]))
            made++;
    endtask

    task automatic send_frame(logic [ID_W-1:0] id, logic [63:0] fr);
        logic [3:0] n;
        n = 4'($urandom_range(8));
        send_word({7'd0, n, fr, id});
    endtask

    task automatic wait_empty();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (tracker.msg_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        wait_empty();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(idx, v);
    endtask

    task automatic set_config(logic [ID_W-1:0] id, logic [7:0] blk, logic [7:0] st,
                              logic fe, logic [7:0] fb);
        settle();
        cfg_write(CFG_RX_ID, id);
        cfg_write(CFG_FLOW_BLOCK, {21'd0, blk});
        cfg_write(CFG_FLOW_STMIN, {21'd0, st});
        cfg_write(CFG_FILL_ENABLE, {28'd0, fe});
        cfg_write(CFG_FILL_BYTE, {21'd0, fb});
    endtask

    task automatic send_noise();
        logic [63:0]     fr;
        logic [ID_W-1:0] flip;
        fr = {$urandom, $urandom};
        case ($urandom_range(3))
            0: begin
                flip = ID_W'($urandom_range(29'h1FFFFFFF, 1));
                send_frame(tracker.rx_id ^ flip, fr);
            end
            1: begin
                fr[63:60] = 4'($urandom_range(15, 4));
                send_frame(tracker.rx_id, fr);
            end
            2: begin
                fr[63:60] = FT_FLOW;
                send_frame(tracker.rx_id, fr);
            end
            default: begin
                fr[63:60] = FT_CONSEC;
                send_frame(tracker.rx_id, fr);
            end
        endcase
    endtask

    task automatic send_message(int len_i, bit clean);
        logic [LEN_W-1:0] len;
        logic [63:0]      fr;
        logic [3:0]       seq;
        logic [3:0]       nib;
        int               r;
        len = LEN_W'(len_i);
        seq = 4'd1;
        fr = {$urandom, $urandom};
        if (len <= 7 && $urandom_range(1) == 1) begin
            nib = len[3:0];
            if (len == 7 && $urandom_range(1) == 1)
                nib = 4'($urandom_range(15, 8));
            fr[63:56] = {FT_SINGLE, nib};
        end else begin
            fr[63:48] = {FT_FIRST, len};
        end
        send_frame(tracker.rx_id, fr);
        while (tracker.in_prog) begin
            r = $urandom_range(99);
            if (!clean && r < 8) begin
                send_noise();
            end else if (!clean && r < 10) begin
                break;
            end else begin
                fr = {$urandom, $urandom};
                fr[63:56] = {FT_CONSEC, seq};
                seq++;
                send_frame(tracker.rx_id, fr);
            end
        end
    endtask

    task automatic run_phase(int target, bit with_long);
        int goal;
        int len;
        bit paused;
        if (with_long)
            send_message(4095, 1'b1);
        goal = made + target;
        paused = 1'b0;
        while (made < goal) begin
            if (!paused && made >= goal - target / 2) begin
                paused = 1'b1;
                wait_empty();
            end
            len = ($urandom_range(39) == 0) ? $urandom_range(4095) : $urandom_range(60);
            send_message(len, 1'b0);
            if ($urandom_range(9) == 0)
                send_noise();
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RX_ID;
        i_cfg_wdata = '0;
        hold_rx = 1'b0;
        send_pct = 30;
        recv_pct = 49;
        made = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_frame('0, {FT_SINGLE, 4'h0, 56'h0});
        send_frame('0, {FT_SINGLE, 4'h7, {56{1'b1}}});
        send_frame('0, frame_with({FT_SINGLE, 4'hF}, 8'h00));
        send_frame('0, frame_with({FT_FIRST, 4'h0}, 8'd0));
        send_frame('0, frame_with({FT_FIRST, 4'h0}, 8'd6));
        send_frame('0, frame_with({FT_CONSEC, 4'h1}, 8'h00));
        send_frame('0, frame_with({FT_FIRST, 4'h0}, 8'd20));
        send_frame('0, frame_with({FT_FLOW, 4'hA}, 8'hFF));
        send_frame('0, frame_with({FT_CONSEC, 4'h1}, 8'h11));
        send_frame('0, frame_with({FT_CONSEC, 4'h2}, 8'h22));
        send_frame('0, frame_with({4'h4, 4'h0}, 8'h00));
        send_frame('0, frame_with({4'hF, 4'hF}, 8'hFF));
        send_frame(29'h1, frame_with({FT_FIRST, 4'h0}, 8'd9));
        send_frame('0, frame_with({FT_FIRST, 4'hF}, 8'hFF));
        send_frame('0, frame_with({FT_SINGLE, 4'h3}, 8'h00));

        set_config(29'h1FFFFFFF, 8'd1, STMIN_US_MAX, 1'b0, 8'hFF);
        send_frame(29'h1FFFFFFF, frame_with({FT_FIRST, 4'h0}, 8'd10));
        send_frame(29'h1FFFFFFF, frame_with({FT_CONSEC, 4'h1}, 8'h00));
        send_frame(29'h1FFFFFFF, frame_with({FT_CONSEC, 4'h2}, 8'h00));
        send_frame(29'h1FFFFFFF, frame_with({FT_FLOW, 4'h0}, 8'h00));

        set_config(ID_W'($urandom), 8'd0, STMIN_MS_MAX + 8'd1, 1'b1, 8'hA5);
        send_frame(tracker.rx_id, frame_with({FT_FIRST, 4'h0}, 8'd13));
        send_frame(tracker.rx_id, frame_with({FT_CONSEC, 4'h1}, 8'h00));
        send_frame(tracker.rx_id, frame_with({FT_CONSEC, 4'h2}, 8'h00));

        set_config(ID_W'($urandom), 8'($urandom_range(16, 2)), pick_stmin(),
                   1'($urandom_range(1)), 8'($urandom));
        run_phase(180, 1'b0);
        set_config(ID_W'($urandom), 8'd255, 8'hFF, 1'b1, 8'h00);
        run_phase(180, 1'b1);

        send_pct = 49;
        recv_pct = 30;
        set_config(ID_W'($urandom), 8'd1, STMIN_MS_MAX, 1'b0, 8'($urandom));
        run_phase(180, 1'b0);
        set_config(ID_W'($urandom), 8'd0, pick_stmin(), 1'b1, 8'($urandom));
        run_phase(180, 1'b0);

        send_pct = 0;
        recv_pct = 0;
        set_config(ID_W'($urandom), 8'd8, pick_stmin(), 1'($urandom_range(1)),
                   8'($urandom));
        fork
            begin
                hold_rx = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none
        run_phase(180, 1'b0);
        set_config('0, 8'($urandom_range(255)), pick_stmin(), 1'($urandom_range(1)),
                   8'($urandom));
        run_phase(180, 1'b0);

        settle();
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ sim.f @@
design/isotp_pkg.sv
design/isotp_mod_unit.sv
design/isotp_frame_reassembler_top.sv
test/tb_isotp_frame_reassembler_top.sv
